// ===== rtl/bms_pkg.sv =====
`default_nettype none

package bms_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int CFG_W           = 6;
    localparam int MAX_SAMPLES_DEF = 32;

    localparam logic [CFG_W-1:0] BATCH_COUNT_RST = CFG_W'(5);

    // broadcast from the control to every cell of the chain
    typedef struct packed {
        logic                       load;
        logic signed [SAMPLE_W-1:0] sample;
    } bms_ins_t;

endpackage

`default_nettype wire

// ===== rtl/batch_median_select_top.sv =====
`default_nettype none

// result path: a sample that completes a batch is inserted into the chain and flagged in
//   pending_reg; the median is then read from the chain into median_reg with done high
// throughput: one sample per cycle with busy held low; the insertion chain places
//   each sample as it is accepted and the median is picked in the following cycle
// reset: batch_count back to 5, fill count cleared, no result pending; cell contents
//   are not reset and never read before written; the receiver cannot stall

module batch_median_select_top
    import bms_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    // sample channel
    input  wire                        start,
    output logic                       busy,
    input  wire signed [SAMPLE_W-1:0]  sample,
    // result channel
    output logic                       done,
    output logic signed [SAMPLE_W-1:0] median,
    // configuration write channel
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire        [CFG_W-1:0]     batch_count
);

    // fill count holds 0..MAX_SAMPLES-1 and its increment reaches MAX_SAMPLES, index selects one cell
    localparam int FW = $clog2(MAX_SAMPLES + 1);
    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int CW = (FW > CFG_W) ? FW : CFG_W;

    logic [CFG_W-1:0] batch_count_reg;
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    fill_next;
    logic [FW-1:0]    fill_inc;
    logic [CW-1:0]    eff_count;
    logic             batch_end;
    logic             pending_reg;
    logic [IW-1:0]    mid_reg;
    logic             done_reg;
    logic signed [SAMPLE_W-1:0] median_reg;

    bms_ins_t ins;

    logic                       cell_gt    [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] cell_value [MAX_SAMPLES];

    // never stalls the sender, config always taken
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign ins.load   = start && !busy;
    assign ins.sample = sample;

    // a zero count acts as one, counts above the chain length saturate
    always_comb
    begin
        if (batch_count_reg == '0)
        begin
            eff_count = CW'(1);
        end
        else if (CW'(batch_count_reg) > CW'(MAX_SAMPLES))
        begin
            eff_count = CW'(MAX_SAMPLES);
        end
        else
        begin
            eff_count = CW'(batch_count_reg);
        end
    end

    assign fill_inc  = fill_reg + FW'(1);
    assign batch_end = ins.load && (CW'(fill_inc) >= eff_count);

    always_comb
    begin
        fill_next = fill_reg;
        if (ins.load)
        begin
            fill_next = batch_end ? '0 : fill_inc;
        end
    end

    // insertion chain: cell 0 at the low end, each cell looks at its lower neighbour
    genvar gi;
    generate
        for (gi = 0; gi < MAX_SAMPLES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                bms_cell u_cell
                (
                    .clk        (clk),
                    .ins        (ins),
                    .occupied   (fill_reg > FW'(gi)),
                    .prev_gt    (1'b0),
                    .prev_value (sample),
                    .gt         (cell_gt[gi]),
                    .value      (cell_value[gi])
                );
            end
            else
            begin : g_rest
                bms_cell u_cell
                (
                    .clk        (clk),
                    .ins        (ins),
                    .occupied   (fill_reg > FW'(gi)),
                    .prev_gt    (cell_gt[gi-1]),
                    .prev_value (cell_value[gi-1]),
                    .gt         (cell_gt[gi]),
                    .value      (cell_value[gi])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_count_reg <= BATCH_COUNT_RST;
            fill_reg        <= '0;
            pending_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                batch_count_reg <= batch_count;
            end
            fill_reg    <= fill_next;
            pending_reg <= batch_end;
            done_reg    <= pending_reg;
        end
    end

    // median index is the upper middle of the completed batch
    always_ff @(posedge clk)
    begin
        if (batch_end)
        begin
            mid_reg <= IW'(fill_inc >> 1);
        end
        if (pending_reg)
        begin
            // reads the chain before any transfer in this cycle updates it
            median_reg <= cell_value[mid_reg];
        end
    end

    assign done   = done_reg;
    assign median = median_reg;

endmodule

`default_nettype wire

// ===== rtl/bms_cell.sv =====
`default_nettype none

module bms_cell
    import bms_pkg::*;
(
    input  wire                        clk,
    input  bms_ins_t                   ins,
    input  wire                        occupied,
    input  wire                        prev_gt,
    input  wire signed [SAMPLE_W-1:0]  prev_value,
    output logic                       gt,
    output logic signed [SAMPLE_W-1:0] value
);

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;

    // held sample is larger than the new one: this cell moves up
    assign gt    = occupied && (value_reg > ins.sample);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ins.load && (!occupied || gt))
        begin
            value_next = prev_gt ? prev_value : ins.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire
